/* rtl/chcp_pkg.sv */
// chcp_pkg: shared types and codes of the canonical huffman code packer
// used by every module under rtl/ but chcp_port_checks, no dependencies
package chcp_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_NEXT   = 2'd1;
    localparam logic [1:0] KIND_ENCODE = 2'd2;
    localparam logic [1:0] KIND_FLUSH  = 2'd3;

    // result error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_LEN_DEC  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    // table write request from the define unit
    typedef struct packed {
        logic        en;
        logic [7:0]  sym;
        logic [5:0]  len;
        logic [31:0] code;
    } wr_req_t;

    // one code table entry as read back
    typedef struct packed {
        logic [5:0]  len;
        logic [31:0] code;
    } entry_t;

endpackage

/* rtl/chcp_table.sv */
// chcp_table: code table memory with per-entry valid bits and write forwarding
// depends on chcp_pkg
module chcp_table #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [7:0]       rd_sym,
    input  chcp_pkg::wr_req_t wr,
    output chcp_pkg::entry_t rd_entry
);
    localparam int IDX_W = $clog2(SYMBOL_COUNT);
    localparam int ENT_W = 6 + MAX_CODE_LEN;

    logic [ENT_W-1:0]        mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;

    logic [ENT_W-1:0]  rd_word_reg;
    logic              rd_hit_reg;
    logic              fwd_reg;
    chcp_pkg::entry_t  fwd_data_reg;

    logic             wr_in;
    logic             rd_in;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;

    assign wr_in  = ({1'b0, wr.sym} < 9'(SYMBOL_COUNT));
    assign rd_in  = ({1'b0, rd_sym} < 9'(SYMBOL_COUNT));
    assign wr_idx = wr.sym[IDX_W-1:0];
    assign rd_idx = rd_sym[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr.en && wr_in) begin
            mem[wr_idx] <= {wr.len, wr.code[MAX_CODE_LEN-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en && wr_in) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // registered read; a write to the same entry in the same cycle is forwarded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_hit_reg <= 1'b0;
            fwd_reg    <= 1'b0;
        end else if (rd_en) begin
            rd_hit_reg <= rd_in && valid_reg[rd_idx];
            fwd_reg    <= wr.en && wr_in && (wr.sym == rd_sym);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_word_reg       <= mem[rd_idx];
            fwd_data_reg.len  <= wr.len;
            fwd_data_reg.code <= wr.code;
        end
    end

    always_comb begin
        priority if (fwd_reg) begin
            rd_entry = fwd_data_reg;
        end else if (rd_hit_reg) begin
            rd_entry.len  = rd_word_reg[ENT_W-1:MAX_CODE_LEN];
            rd_entry.code = 32'(rd_word_reg[MAX_CODE_LEN-1:0]);
        end else begin
            rd_entry = '0;
        end
    end

endmodule

/* rtl/chcp_define.sv */
// chcp_define: canonical code assignment for define beats
// depends on chcp_pkg
module chcp_define #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [1:0]        kind,
    input  logic [7:0]        sym,
    input  logic [5:0]        len,
    output logic [31:0]       assigned_code,
    output logic [1:0]        error_code,
    output chcp_pkg::wr_req_t wr
);
    localparam int CW = MAX_CODE_LEN;

    logic [CW-1:0] prev_code_reg, prev_code_next;
    logic [5:0]    prev_len_reg, prev_len_next;

    logic          is_def;
    logic          bad_len;
    logic          len_dec;
    logic          ovf;
    logic [CW:0]   inc;
    logic [CW:0]   code_shift;
    logic [CW-1:0] code;
    logic [1:0]    err;
    logic          ok;

    assign is_def     = (kind == chcp_pkg::KIND_FIRST) || (kind == chcp_pkg::KIND_NEXT);
    assign bad_len    = (len == 6'd0) || (len > 6'(MAX_CODE_LEN));
    assign len_dec    = (len < prev_len_reg);
    assign inc        = {1'b0, prev_code_reg} + (CW+1)'(1);
    assign ovf        = ((inc >> prev_len_reg) != '0);
    assign code_shift = inc << (len - prev_len_reg);

    always_comb begin
        err  = chcp_pkg::ERR_OK;
        code = '0;
        priority if (bad_len) begin
            err = chcp_pkg::ERR_OVERFLOW;
        end else if (kind == chcp_pkg::KIND_FIRST) begin
            code = '0;
        end else if (len_dec) begin
            err = chcp_pkg::ERR_LEN_DEC;
        end else if (ovf) begin
            err = chcp_pkg::ERR_OVERFLOW;
        end else begin
            code = code_shift[CW-1:0];
        end
    end

    assign ok            = is_def && (err == chcp_pkg::ERR_OK);
    assign assigned_code = ok ? 32'(code) : 32'd0;
    assign error_code    = is_def ? err : chcp_pkg::ERR_OK;

    assign wr.en   = step && ok;
    assign wr.sym  = sym;
    assign wr.len  = len;
    assign wr.code = 32'(code);

    assign prev_code_next = wr.en ? code : prev_code_reg;
    assign prev_len_next  = wr.en ? len : prev_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_code_reg <= '0;
            prev_len_reg  <= '0;
        end else begin
            prev_code_reg <= prev_code_next;
            prev_len_reg  <= prev_len_next;
        end
    end

endmodule

/* rtl/chcp_packer.sv */
// chcp_packer: msb-first bit accumulator, emits full words and flush words
// depends on chcp_pkg
module chcp_packer #(
    parameter int WORD_BITS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [1:0]       kind,
    input  chcp_pkg::entry_t entry,
    output logic             word_valid,
    output logic [63:0]      packed_word,
    output logic [6:0]       word_bits
);
    localparam int FILL_W = $clog2(WORD_BITS);
    localparam int TOT_W  = FILL_W + 1;

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;

    logic [TOT_W-1:0]     len_w;
    logic [TOT_W-1:0]     total;
    logic [TOT_W-1:0]     over;
    logic                 full;
    logic                 has_code;
    logic [WORD_BITS-1:0] code_w;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] carry;
    logic [63:0]          enc_word;
    logic [63:0]          flush_word;

    assign len_w    = TOT_W'(entry.len);
    assign total    = TOT_W'(fill_reg) + len_w;
    assign full     = (total >= TOT_W'(WORD_BITS));
    assign over     = total - TOT_W'(WORD_BITS);
    assign has_code = (entry.len != 6'd0);
    assign code_w   = WORD_BITS'(entry.code);

    // pending bits sit right-aligned; only the leftover low code bits carry
    assign word       = (acc_reg << (TOT_W'(WORD_BITS) - TOT_W'(fill_reg))) | (code_w >> over);
    assign carry      = code_w & ((WORD_BITS'(1) << over) - WORD_BITS'(1));
    assign enc_word   = 64'(word) << 7'(64 - WORD_BITS);
    assign flush_word = 64'(acc_reg) << (7'd64 - 7'(fill_reg));

    always_comb begin
        word_valid  = 1'b0;
        packed_word = '0;
        word_bits   = '0;
        acc_next    = acc_reg;
        fill_next   = fill_reg;
        unique case (kind)
            chcp_pkg::KIND_ENCODE: begin
                if (has_code) begin
                    if (full) begin
                        word_valid  = 1'b1;
                        packed_word = enc_word;
                        word_bits   = 7'(WORD_BITS);
                        acc_next    = carry;
                        fill_next   = FILL_W'(over);
                    end else begin
                        acc_next  = (acc_reg << len_w) | code_w;
                        fill_next = FILL_W'(total);
                    end
                end
            end
            chcp_pkg::KIND_FLUSH: begin
                if (fill_reg != '0) begin
                    word_valid  = 1'b1;
                    packed_word = flush_word;
                    word_bits   = 7'(fill_reg);
                    acc_next    = '0;
                    fill_next   = '0;
                end
            end
            chcp_pkg::KIND_FIRST, chcp_pkg::KIND_NEXT: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            fill_reg <= '0;
        end else if (step) begin
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
        end
    end

endmodule

/* rtl/canonical_huffman_code_packer_unit.sv */
// an accepted s_ beat: table read in stage 1, then update into the output register on m_
// throughput: one beat per cycle while m_tready does not stall, set by the single registered
// read port of the code table and the read-modify-write of the define and packing state
// a define followed at once by an encode of the same symbol is served by write forwarding
// reset: synchronous active-low aresetn clears all valid bits of the table at once,
// the code and packing state and the pipeline; no clearing pass, a beat is taken right after
module canonical_huffman_code_packer_unit #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32,
    parameter int WORD_BITS    = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // symbol [7:0], code_length [13:8], zero [15:14]
    input  logic [1:0]   s_tuser,   // kind [1:0]
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // packed_word [63:0], word_bits [70:64],
                                    // assigned_code [102:71], error_code [104:103],
                                    // zero [111:105]
    output logic         m_tuser    // word_valid
);
    // stage 1: item waiting on the table read
    logic       s1_valid_reg;
    logic [1:0] s1_kind_reg;
    logic [7:0] s1_sym_reg;
    logic [5:0] s1_len_reg;

    // output register, parts the two sides
    logic         m_valid_reg, m_valid_next;
    logic [111:0] m_data_reg;
    logic         m_user_reg;

    logic advance;
    logic s_accept;
    logic step;

    chcp_pkg::wr_req_t wr;
    chcp_pkg::entry_t  entry;

    logic [31:0] assigned_code;
    logic [1:0]  error_code;
    logic        word_valid;
    logic [63:0] packed_word;
    logic [6:0]  word_bits;

    // the output register can take a new result when empty or being drained
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign step     = s1_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg <= s_tuser;
            s1_sym_reg  <= s_tdata[7:0];
            s1_len_reg  <= s_tdata[13:8];
        end
    end

    // code table, read on acceptance, written by the define unit in stage 1
    chcp_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_sym   (s_tdata[7:0]),
        .wr       (wr),
        .rd_entry (entry)
    );

    // canonical code assignment
    chcp_define #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_define (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .kind          (s1_kind_reg),
        .sym           (s1_sym_reg),
        .len           (s1_len_reg),
        .assigned_code (assigned_code),
        .error_code    (error_code),
        .wr            (wr)
    );

    // bit packing of looked-up codes
    chcp_packer #(
        .WORD_BITS (WORD_BITS)
    ) u_packer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .kind        (s1_kind_reg),
        .entry       (entry),
        .word_valid  (word_valid),
        .packed_word (packed_word),
        .word_bits   (word_bits)
    );

    // every item yields exactly one result beat
    assign m_valid_next = advance ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= {7'd0, error_code, assigned_code, word_bits, packed_word};
            m_user_reg <= word_valid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* rtl/chcp_checker.sv */
// chcp_port_checks: port-level checks of the code packer result channel
// bound to canonical_huffman_code_packer_unit, no package dependency
module chcp_port_checks (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [15:0]  s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tuser
);
    // a stalled result beat holds its content
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // no word: packed bits and bit count are zero
    a_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[70:0] == 71'd0)
        else $error("word fields set without word_valid");

    // a word beat carries bits and no define result
    a_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[70:64] != 7'd0 && m_tdata[104:71] == 34'd0)
        else $error("word beat with empty count or define fields");

    // a refused define gives no code
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[104:103] != 2'd0 |-> m_tdata[102:71] == 32'd0 && !m_tuser)
        else $error("error beat carries a code or word");

    // nothing is presented right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat presented after reset");

endmodule

bind canonical_huffman_code_packer_unit chcp_port_checks u_chcp_checker (.*);

/* tb/chcp_checker.sv */
// chcp_checker: watches both stream channels of the code packer, predicts every result beat
// and compares it field by field; depends on chcp_pkg for item kinds and error codes
module chcp_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [15:0]    s_tdata,
    input  logic [1:0]     s_tuser,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [111:0]   m_tdata,
    input  logic           m_tuser,
    output int unsigned    mismatches,
    output int unsigned    results_due
);

    localparam int TABLE_DEPTH  = 256;
    localparam int LONGEST_CODE = 32;
    localparam int WORD_W       = 64;

    typedef struct packed {
        logic        word_valid;
        logic [63:0] packed_word;
        logic [6:0]  word_bits;
        logic [31:0] assigned_code;
        logic [1:0]  error_code;
    } packer_result_t;

    // predicted code book and packing state
    logic [5:0]     book_len  [TABLE_DEPTH];
    logic [31:0]    book_code [TABLE_DEPTH];
    logic [31:0]    last_code;
    logic [5:0]     last_len;
    logic [63:0]    bit_store;
    logic [6:0]     bits_held;
    packer_result_t packer_results_q[$];

    function automatic packer_result_t predict_packer_item(input logic [1:0] kind,
                                                           input logic [7:0] sym,
                                                           input logic [5:0] len);
        packer_result_t r;
        logic [32:0]    bumped;
        logic [63:0]    code;
        logic [6:0]     total;
        logic [6:0]     spill;
        r = '0;
        case (kind)
            chcp_pkg::KIND_FIRST, chcp_pkg::KIND_NEXT: begin
                bumped = {1'b0, last_code} + 33'd1;
                if (len == 6'd0 || len > LONGEST_CODE) begin
                    r.error_code = chcp_pkg::ERR_OVERFLOW;
                end else if (kind == chcp_pkg::KIND_NEXT && len < last_len) begin
                    r.error_code = chcp_pkg::ERR_LEN_DEC;
                end else if (kind == chcp_pkg::KIND_NEXT
                             && (bumped >> last_len) != 33'd0) begin
                    r.error_code = chcp_pkg::ERR_OVERFLOW;
                end else begin
                    code = (kind == chcp_pkg::KIND_FIRST) ? 64'd0
                                                          : (64'(bumped) << (len - last_len));
                    if (int'(sym) < TABLE_DEPTH) begin
                        book_len[sym]  = len;
                        book_code[sym] = code[31:0];
                    end
                    last_code       = code[31:0];
                    last_len        = len;
                    r.assigned_code = code[31:0];
                end
            end
            chcp_pkg::KIND_ENCODE: begin
                if (int'(sym) < TABLE_DEPTH && book_len[sym] != 6'd0) begin
                    code  = 64'(book_code[sym]);
                    total = bits_held + 7'(book_len[sym]);
                    if (total < WORD_W) begin
                        bit_store = (bit_store << book_len[sym]) | code;
                        bits_held = total;
                    end else begin
                        // word complete, only the bits that did not fit are carried
                        spill         = total - 7'(WORD_W);
                        r.word_valid  = 1'b1;
                        r.packed_word = (bit_store << (WORD_W - int'(bits_held)))
                                        | (code >> spill);
                        r.word_bits   = 7'(WORD_W);
                        bit_store     = code & ((64'd1 << spill) - 64'd1);
                        bits_held     = spill;
                    end
                end
            end
            default: begin
                if (bits_held != 7'd0) begin
                    r.word_valid  = 1'b1;
                    r.packed_word = (bit_store & ((64'd1 << bits_held) - 64'd1))
                                    << (WORD_W - int'(bits_held));
                    r.word_bits   = bits_held;
                    bit_store     = '0;
                    bits_held     = '0;
                end
            end
        endcase
        return r;
    endfunction

    initial begin
        mismatches  = 0;
        results_due = 0;
    end

    always @(posedge aclk) begin
        packer_result_t want;
        packer_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                book_len[i]  = '0;
                book_code[i] = '0;
            end
            last_code = '0;
            last_len  = '0;
            bit_store = '0;
            bits_held = '0;
            packer_results_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.word_valid    = m_tuser;
                got.packed_word   = m_tdata[63:0];
                got.word_bits     = m_tdata[70:64];
                got.assigned_code = m_tdata[102:71];
                got.error_code    = m_tdata[104:103];
                if (packer_results_q.size() == 0) begin
                    $display("%0t: result beat with none expected, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = packer_results_q.pop_front();
                    if (got.word_valid !== want.word_valid) begin
                        $display("%0t: word_valid expected %0d got %0d",
                                 $time, want.word_valid, got.word_valid);
                        mismatches++;
                    end
                    if (got.packed_word !== want.packed_word) begin
                        $display("%0t: packed_word expected %h got %h",
                                 $time, want.packed_word, got.packed_word);
                        mismatches++;
                    end
                    if (got.word_bits !== want.word_bits) begin
                        $display("%0t: word_bits expected %0d got %0d",
                                 $time, want.word_bits, got.word_bits);
                        mismatches++;
                    end
                    if (got.assigned_code !== want.assigned_code) begin
                        $display("%0t: assigned_code expected %h got %h",
                                 $time, want.assigned_code, got.assigned_code);
                        mismatches++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $display("%0t: error_code expected %0d got %0d",
                                 $time, want.error_code, got.error_code);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                packer_results_q.push_back(
                    predict_packer_item(s_tuser, s_tdata[7:0], s_tdata[13:8]));
            end
        end
        results_due = packer_results_q.size();
    end

endmodule

/* tb/tb_top.sv */
// tb_top: drives the canonical huffman code packer with directed and random beats
// and gives the verdict; depends on chcp_pkg, the packer unit and chcp_checker
module tb_top;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [15:0]    s_tdata;    // symbol [7:0], code_length [13:8], zero [15:14]
    logic [1:0]     s_tuser;    // kind [1:0]
    logic           m_tvalid;
    logic           m_tready;
    logic [111:0]   m_tdata;    // packed_word [63:0], word_bits [70:64],
                                // assigned_code [102:71], error_code [104:103], zero [111:105]
    logic           m_tuser;    // word_valid
    int unsigned    mismatches;
    int unsigned    results_due;

    // percentages of idle cycles on each side, changed per phase
    int unsigned    tx_idle_pct;
    int unsigned    rx_idle_pct;
    // asks the receiver for one long hold-off
    logic           hold_rx;
    int unsigned    items_sent;

    always #4 aclk = ~aclk;

    canonical_huffman_code_packer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    chcp_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // offer one beat from a falling edge, hold it until taken, return at a falling edge
    task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                             input logic [5:0] len);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {2'b00, len, sym};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // sender pause until every predicted result has come back
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (results_due != 0) @(negedge aclk);
    endtask

    // mostly well-formed code books followed by runs of encodes, plus broken
    // definitions and random noise beats
    task automatic run_phase(input int unsigned quota);
        int unsigned stop_at;
        int unsigned r;
        int unsigned first_len;
        int unsigned book_size;
        int unsigned len_now;
        int unsigned cap;
        logic [7:0]  book_syms[$];
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 80) begin
                // code book with kraft sum below one, so no definition overflows
                book_syms.delete();
                first_len = $urandom_range(1, 8);
                cap       = (1 << first_len) - 1;
                book_size = $urandom_range(1, (cap > 40) ? 40 : cap);
                len_now   = first_len;
                for (int i = 0; i < book_size; i++) begin
                    if (i > 0 && $urandom_range(2) == 0) begin
                        len_now = len_now + $urandom_range(1, 8);
                        if (len_now > 32) len_now = 32;
                    end
                    book_syms.push_back(8'($urandom_range(255)));
                    send_item((i == 0) ? chcp_pkg::KIND_FIRST : chcp_pkg::KIND_NEXT,
                              book_syms[i], 6'(len_now));
                end
                repeat ($urandom_range(8, 60)) begin
                    if ($urandom_range(11) == 0) begin
                        send_item(chcp_pkg::KIND_FLUSH, 8'($urandom_range(255)),
                                  6'($urandom_range(63)));
                    end else begin
                        send_item(chcp_pkg::KIND_ENCODE,
                                  book_syms[$urandom_range(book_syms.size() - 1)],
                                  6'($urandom_range(63)));
                    end
                end
                if ($urandom_range(1) == 1) begin
                    send_item(chcp_pkg::KIND_FLUSH, 8'($urandom_range(255)),
                              6'($urandom_range(63)));
                end
            end else if (r < 90) begin
                // define-next of random length, which may be refused, then encodes against whatever the table holds
                send_item(chcp_pkg::KIND_NEXT, 8'($urandom_range(255)),
                          6'($urandom_range(63)));
                repeat ($urandom_range(1, 6)) begin
                    send_item(chcp_pkg::KIND_ENCODE, 8'($urandom_range(255)),
                              6'($urandom_range(63)));
                end
            end else begin
                repeat ($urandom_range(3, 12)) begin
                    send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                              6'($urandom_range(63)));
                end
            end
        end
    endtask

    // receiver: random ready per cycle, plus one long counted hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx) begin
                hold_rx  = 1'b0;
                m_tready = 1'b0;
                repeat (300) @(negedge aclk);
            end
            m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // stimulus and verdict
    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = chcp_pkg::KIND_FIRST;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_rx     = 1'b0;
        items_sent  = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // define-next with no define-first before it overflows
        send_item(chcp_pkg::KIND_NEXT,   8'h05, 6'd4);
        // bad lengths: zero, one above the longest code, all ones
        send_item(chcp_pkg::KIND_FIRST,  8'h10, 6'd0);
        send_item(chcp_pkg::KIND_FIRST,  8'h11, 6'd33);
        send_item(chcp_pkg::KIND_FIRST,  8'h12, 6'd63);
        // encode of a symbol never defined, then a flush with nothing pending
        send_item(chcp_pkg::KIND_ENCODE, 8'h00, 6'd0);
        send_item(chcp_pkg::KIND_FLUSH,  8'h00, 6'd0);
        // full one-bit code book, a third one-bit code overflows
        send_item(chcp_pkg::KIND_FIRST,  8'h00, 6'd1);
        send_item(chcp_pkg::KIND_NEXT,   8'hff, 6'd1);
        send_item(chcp_pkg::KIND_NEXT,   8'h07, 6'd1);
        // long codes with their top bit set, then a shorter length is refused
        send_item(chcp_pkg::KIND_FIRST,  8'h01, 6'd1);
        send_item(chcp_pkg::KIND_NEXT,   8'h02, 6'd32);
        send_item(chcp_pkg::KIND_NEXT,   8'h03, 6'd32);
        send_item(chcp_pkg::KIND_NEXT,   8'h04, 6'd5);
        // symbol 0 gets a new entry over its old one
        send_item(chcp_pkg::KIND_FIRST,  8'h00, 6'd3);
        // 1 + 32 + 32 bits crosses a word, one bit carried over
        send_item(chcp_pkg::KIND_ENCODE, 8'hff, 6'd0);
        send_item(chcp_pkg::KIND_ENCODE, 8'h02, 6'd0);
        send_item(chcp_pkg::KIND_ENCODE, 8'h03, 6'd0);
        send_item(chcp_pkg::KIND_ENCODE, 8'h00, 6'd0);
        send_item(chcp_pkg::KIND_FLUSH,  8'h00, 6'd0);
        // exactly one word, nothing left for the flush
        send_item(chcp_pkg::KIND_ENCODE, 8'h03, 6'd0);
        send_item(chcp_pkg::KIND_ENCODE, 8'h02, 6'd0);
        send_item(chcp_pkg::KIND_FLUSH,  8'h00, 6'd0);
        // define followed at once by an encode of the same symbol
        send_item(chcp_pkg::KIND_FIRST,  8'h09, 6'd32);
        send_item(chcp_pkg::KIND_ENCODE, 8'h09, 6'd0);
        send_item(chcp_pkg::KIND_FLUSH,  8'h00, 6'd0);
        wait_drained();

        // slow receiver
        tx_idle_pct = 9;
        rx_idle_pct = 69;
        run_phase(500);
        wait_drained();

        // slow sender
        tx_idle_pct = 69;
        rx_idle_pct = 9;
        run_phase(500);
        wait_drained();

        // full rate, with one long receiver hold-off so the block backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_rx     = 1'b1;
        run_phase(500);
        wait_drained();
        repeat (20) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/chcp_pkg.sv
rtl/chcp_table.sv
rtl/chcp_define.sv
rtl/chcp_packer.sv
rtl/canonical_huffman_code_packer_unit.sv
rtl/chcp_checker.sv
tb/chcp_checker.sv
tb/tb_top.sv
